// ===== design/blp_pkg.sv =====
// Shared constants and controller/datapath interface types for the line point generator.
package blp_pkg;

  // Default coordinate width: a 64 by 64 grid.
  localparam int COORD_BITS_DEF = 6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture a new pair of endpoints and set up the walk
    logic step;  // advance to the next point of the current line
  } blp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;  // the point now held is the end point
  } blp_sts_t;

endpackage

// ===== design/blp_dp.sv =====
// Datapath: endpoint set-up, point registers and the error-term update.
module blp_dp #(
  parameter int COORD_BITS = blp_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  blp_pkg::blp_cmd_t     cmd,
  output blp_pkg::blp_sts_t     sts,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic [COORD_BITS-1:0] point_x,
  output logic [COORD_BITS-1:0] point_y
);

  // The error term stays within (-2*dmaj, 2*dmin], so two guard bits and a sign suffice.
  localparam int E_BITS = COORD_BITS + 3;

  logic [COORD_BITS:0]   dx_w, dy_w;
  logic [COORD_BITS:0]   adx_w, ady_w;
  logic [COORD_BITS-1:0] adx, ady;
  logic                  x_major;
  logic [COORD_BITS-1:0] dmaj, dmin;
  logic signed [E_BITS-1:0] err0;

  logic [COORD_BITS-1:0] maj_r, maj_nxt;
  logic [COORD_BITS-1:0] mnr_r, mnr_nxt;
  logic [COORD_BITS-1:0] maj_end_r, maj_end_nxt;
  logic [COORD_BITS-1:0] dmaj_r, dmaj_nxt;
  logic [COORD_BITS-1:0] dmin_r, dmin_nxt;
  logic                  maj_dec_r, maj_dec_nxt;
  logic                  mnr_dec_r, mnr_dec_nxt;
  logic                  x_major_r, x_major_nxt;
  logic signed [E_BITS-1:0] err_r, err_nxt;

  logic                  err_pos;
  logic signed [E_BITS-1:0] dmin2, diff2;

  // Differences and magnitudes of the new endpoints.
  always_comb begin
    dx_w  = {1'b0, end_x} - {1'b0, start_x};
    dy_w  = {1'b0, end_y} - {1'b0, start_y};
    adx_w = dx_w[COORD_BITS] ? (~dx_w + 1'b1) : dx_w;
    ady_w = dy_w[COORD_BITS] ? (~dy_w + 1'b1) : dy_w;
    adx   = adx_w[COORD_BITS-1:0];
    ady   = ady_w[COORD_BITS-1:0];
    // Ties go to y.
    x_major = ady < adx;
    dmaj    = x_major ? adx : ady;
    dmin    = x_major ? ady : adx;
    err0    = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
  end

  // Increments of the error term for the two cases of a step.
  always_comb begin
    dmin2   = $signed({2'b00, dmin_r, 1'b0});
    diff2   = $signed({2'b00, dmin_r, 1'b0}) - $signed({2'b00, dmaj_r, 1'b0});
    err_pos = !err_r[E_BITS-1] && (err_r != '0);
  end

  always_comb begin
    maj_nxt     = maj_r;
    mnr_nxt     = mnr_r;
    maj_end_nxt = maj_end_r;
    dmaj_nxt    = dmaj_r;
    dmin_nxt    = dmin_r;
    maj_dec_nxt = maj_dec_r;
    mnr_dec_nxt = mnr_dec_r;
    x_major_nxt = x_major_r;
    err_nxt     = err_r;
    if (cmd.load) begin
      x_major_nxt = x_major;
      maj_nxt     = x_major ? start_x : start_y;
      mnr_nxt     = x_major ? start_y : start_x;
      maj_end_nxt = x_major ? end_x : end_y;
      dmaj_nxt    = dmaj;
      dmin_nxt    = dmin;
      maj_dec_nxt = x_major ? dx_w[COORD_BITS] : dy_w[COORD_BITS];
      mnr_dec_nxt = x_major ? dy_w[COORD_BITS] : dx_w[COORD_BITS];
      err_nxt     = err0;
    end else if (cmd.step) begin
      maj_nxt = maj_dec_r ? (maj_r - 1'b1) : (maj_r + 1'b1);
      if (err_pos) begin
        mnr_nxt = mnr_dec_r ? (mnr_r - 1'b1) : (mnr_r + 1'b1);
        err_nxt = err_r + diff2;
      end else begin
        err_nxt = err_r + dmin2;
      end
    end
  end

  // Cleared at reset so that the point and status outputs are defined before the first line.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maj_r     <= '0;
      mnr_r     <= '0;
      maj_end_r <= '0;
      dmaj_r    <= '0;
      dmin_r    <= '0;
      maj_dec_r <= 1'b0;
      mnr_dec_r <= 1'b0;
      x_major_r <= 1'b0;
      err_r     <= '0;
    end else begin
      maj_r     <= maj_nxt;
      mnr_r     <= mnr_nxt;
      maj_end_r <= maj_end_nxt;
      dmaj_r    <= dmaj_nxt;
      dmin_r    <= dmin_nxt;
      maj_dec_r <= maj_dec_nxt;
      mnr_dec_r <= mnr_dec_nxt;
      x_major_r <= x_major_nxt;
      err_r     <= err_nxt;
    end
  end

  assign sts.last = (maj_r == maj_end_r);
  assign point_x  = x_major_r ? maj_r : mnr_r;
  assign point_y  = x_major_r ? mnr_r : maj_r;

  // A step is never asked for once the end point is reached.
  a_no_step_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !cmd.load) |-> !sts.last)
    else $error("step requested at the end point");

  // Every step moves the major coordinate by exactly one.
  a_major_moves_one: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !cmd.load) |=>
      ((maj_r == $past(maj_r) + 1'b1) || (maj_r == $past(maj_r) - 1'b1)))
    else $error("major coordinate did not move by one");

  // The point registers and the error term never move without a command.
  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.step && !cmd.load) |=> ($stable(maj_r) && $stable(mnr_r) && $stable(err_r)))
    else $error("point registers changed without a command");

endmodule

// ===== design/blp_ctrl.sv =====
// Controller: handshake sequencing and datapath commands for one line at a time.
module blp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  blp_pkg::blp_sts_t     sts,
  output blp_pkg::blp_cmd_t     cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r, state_nxt;
  logic   final_taken;

  // The end point leaving frees the block for the next line in the same cycle.
  assign final_taken = (state_r == ST_RUN) && out_tready && sts.last;
  assign in_tready   = (state_r == ST_IDLE) || final_taken;
  assign out_tvalid  = (state_r == ST_RUN);

  always_comb begin
    cmd.load = in_tvalid && in_tready;
    cmd.step = (state_r == ST_RUN) && out_tready && !sts.last;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.load)         state_nxt = ST_RUN;
        else if (final_taken) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A new line is only taken when nothing of the previous one is left to send.
  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> ((state_r == ST_IDLE) || final_taken))
    else $error("new line loaded while points remain");

  // Load and step are never issued together.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.step))
    else $error("load and step issued together");

  // After a load a point is on offer in the next cycle.
  a_load_gives_point: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_tvalid)
    else $error("no point offered after a load");

endmodule

// ===== design/bresenham_line_points.sv =====
// Top level of the Bresenham line point generator.
//
//  channel  | direction | tdata (low bit first)                    | tuser | tlast
//  ---------+-----------+------------------------------------------+-------+------------
//  in_      | sink      | start_x, start_y, end_x, end_y, zero pad | none  | none
//  out_     | source    | point_x, point_y, zero pad               | none  | last_point
//
// A line from start to end yields |dmajor| + 1 words, one per clock while the sink
// is ready, so from 1 up to 2^COORD_BITS words (64 on the default grid); the walk
// is set by the datapath stepping the major coordinate by one per accepted word.
// The first point is offered the cycle after the endpoints are accepted. A new pair
// of endpoints is accepted in the same cycle as the end point of the previous line is
// taken, so lines follow one another without a gap. A stalled sink simply holds the
// current point; reset (synchronous, active low) returns the controller to idle.
module bresenham_line_points #(
  parameter int COORD_BITS = blp_pkg::COORD_BITS_DEF,
  localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // Endpoints word.
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // start_x, start_y, end_x, end_y, from bit 0 up
  // Line point word.
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // point_x, point_y, from bit 0 up
  output logic             out_tlast   // last_point: set on the end point of the line
);

  blp_pkg::blp_cmd_t cmd;
  blp_pkg::blp_sts_t sts;

  logic [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
  logic [COORD_BITS-1:0] point_x, point_y;

  // Unpack the endpoints word; padding bits above the fields are ignored.
  assign start_x = in_tdata[0*COORD_BITS +: COORD_BITS];
  assign start_y = in_tdata[1*COORD_BITS +: COORD_BITS];
  assign end_x   = in_tdata[2*COORD_BITS +: COORD_BITS];
  assign end_y   = in_tdata[3*COORD_BITS +: COORD_BITS];

  blp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  blp_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .point_x (point_x),
    .point_y (point_y)
  );

  // Pack the point word with zeros above the two coordinates.
  always_comb begin
    out_tdata                              = '0;
    out_tdata[0*COORD_BITS +: COORD_BITS]  = point_x;
    out_tdata[1*COORD_BITS +: COORD_BITS]  = point_y;
  end

  assign out_tlast = sts.last;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the Bresenham line point generator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB        = blp_pkg::COORD_BITS_DEF;
  localparam int IN_W      = ((4 * CB + 7) / 8) * 8;
  localparam int OUT_W     = ((2 * CB + 7) / 8) * 8;
  localparam int MAX_COORD = (1 << CB) - 1;
  localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int TAIL_CYCLES = 80;    // settle time once every point has arrived
  localparam int CALM_FIRST  = 120;   // words sent in this range see no idling
  localparam int CALM_LAST   = 200;

  // One pair of endpoints; hold makes the driver wait until the block has drained.
  typedef struct packed {
    logic          hold;
    logic [CB-1:0] start_x;
    logic [CB-1:0] start_y;
    logic [CB-1:0] end_x;
    logic [CB-1:0] end_y;
  } endpoints_t;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          last;
  } point_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  endpoints_t line_q[$];    // endpoints still to be offered
  point_t     points_q[$];  // line points predicted but not yet seen
  int         n_sent     = 0;
  int         n_accepted = 0;
  int         mismatches = 0;
  int         idle_cycles = 0;
  logic       calm;

  bresenham_line_points u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  assign calm = (n_sent >= CALM_FIRST) && (n_sent < CALM_LAST);

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Walk the line from start to end and queue every point it passes through.
  // The major axis is x only when |dx| strictly exceeds |dy|, so ties walk along y.
  task automatic trace_line(input endpoints_t ep);
    int   maj, mnr, maj_end, mnr_end, dmaj, dmin, mstep, jstep, err, n;
    logic x_major, done;
    point_t p;
    x_major = mag(int'(ep.end_y) - int'(ep.start_y)) < mag(int'(ep.end_x) - int'(ep.start_x));
    maj     = x_major ? int'(ep.start_x) : int'(ep.start_y);
    mnr     = x_major ? int'(ep.start_y) : int'(ep.start_x);
    maj_end = x_major ? int'(ep.end_x)   : int'(ep.end_y);
    mnr_end = x_major ? int'(ep.end_y)   : int'(ep.end_x);
    dmaj    = mag(maj_end - maj);
    dmin    = mag(mnr_end - mnr);
    mstep   = (mnr_end < mnr) ? -1 : 1;
    jstep   = (maj < maj_end) ? 1 : -1;
    err     = 2 * dmin - dmaj;
    n       = 0;
    done    = 1'b0;
    while (!done) begin
      p.x    = x_major ? maj[CB-1:0] : mnr[CB-1:0];
      p.y    = x_major ? mnr[CB-1:0] : maj[CB-1:0];
      p.last = (maj == maj_end);
      points_q.push_back(p);
      n++;
      if (p.last || n >= (1 << CB)) begin
        done = 1'b1;
      end else begin
        maj += jstep;
        if (err > 0) begin
          mnr += mstep;
          err += 2 * (dmin - dmaj);
        end else begin
          err += 2 * dmin;
        end
      end
    end
  endtask

  task automatic add_line(input int sx, input int sy, input int ex, input int ey,
                          input bit hold);
    endpoints_t ep;
    ep.hold    = hold;
    ep.start_x = sx[CB-1:0];
    ep.start_y = sy[CB-1:0];
    ep.end_x   = ex[CB-1:0];
    ep.end_y   = ey[CB-1:0];
    line_q.push_back(ep);
  endtask

  // Driver: a new word goes out at the falling edge once the previous one was taken.
  // An item marked hold is kept back until every predicted point has been seen.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 35);
      if (!in_tvalid || n_accepted == n_sent) begin
        if (line_q.size() != 0 && (calm || $urandom_range(99) >= 35) &&
            !(line_q[0].hold && points_q.size() != 0)) begin
          in_tdata  <= {line_q[0].end_y, line_q[0].end_x,
                        line_q[0].start_y, line_q[0].start_x};
          in_tvalid <= 1'b1;
          n_sent    <= n_sent + 1;
          void'(line_q.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on every accepted endpoints word, check every accepted point.
  always @(posedge clk) begin
    endpoints_t got_ep;
    point_t     want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        got_ep.hold    = 1'b0;
        got_ep.start_x = in_tdata[CB-1:0];
        got_ep.start_y = in_tdata[2*CB-1:CB];
        got_ep.end_x   = in_tdata[3*CB-1:2*CB];
        got_ep.end_y   = in_tdata[4*CB-1:3*CB];
        n_accepted <= n_accepted + 1;
      end
      // The new line may start in the cycle its predecessor ends, so check first.
      if (out_tvalid && out_tready) begin
        if (points_q.size() == 0) begin
          $display("%0t: unexpected point: got x=%0d y=%0d last=%0b", $time,
                   out_tdata[CB-1:0], out_tdata[2*CB-1:CB], out_tlast);
          mismatches++;
        end else begin
          want = points_q.pop_front();
          if (out_tdata[CB-1:0] !== want.x || out_tdata[2*CB-1:CB] !== want.y ||
              out_tlast !== want.last) begin
            $display("%0t: point mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     $time, want.x, want.y, want.last,
                     out_tdata[CB-1:0], out_tdata[2*CB-1:CB], out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        trace_line(got_ep);
      end
    end
  end

  // Watchdog: a run where no word moves for too long has hung.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int a, b, d, sx, sy, ex, ey, kind;

    // Single points, both corners.
    add_line(0, 0, 0, 0, 0);
    add_line(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 0);
    // Full diagonals: ties go to the y axis.
    add_line(0, 0, MAX_COORD, MAX_COORD, 0);
    add_line(MAX_COORD, MAX_COORD, 0, 0, 0);
    add_line(0, MAX_COORD, MAX_COORD, 0, 0);
    add_line(MAX_COORD, 0, 0, MAX_COORD, 0);
    // Horizontal and vertical, both directions.
    add_line(0, 5, MAX_COORD, 5, 0);
    add_line(MAX_COORD, 40, 0, 40, 0);
    add_line(7, 0, 7, MAX_COORD, 0);
    add_line(50, MAX_COORD, 50, 0, 0);
    // Shallow lines in all four directions.
    add_line(0, 0, MAX_COORD, 20, 0);
    add_line(MAX_COORD, 0, 0, 20, 0);
    add_line(0, MAX_COORD, MAX_COORD, 43, 0);
    add_line(MAX_COORD, MAX_COORD, 0, 43, 0);
    // Steep lines in all four directions.
    add_line(0, 0, 20, MAX_COORD, 0);
    add_line(20, 0, 0, MAX_COORD, 0);
    add_line(0, MAX_COORD, 20, 0, 0);
    add_line(20, MAX_COORD, 0, 0, 0);
    // Short lines of one to three steps.
    add_line(10, 10, 11, 10, 0);
    add_line(10, 10, 10, 11, 0);
    add_line(10, 10, 11, 11, 0);
    add_line(5, 5, 8, 2, 0);
    // Hold off until the block has drained for a single point, then a long diagonal right after.
    add_line(33, 17, 33, 17, 1);
    add_line(1, 62, 62, 1, 0);

    for (int i = 0; i < 380; i++) begin
      kind = $urandom_range(99);
      sx   = $urandom_range(MAX_COORD);
      sy   = $urandom_range(MAX_COORD);
      if (kind < 45) begin
        // Short lines keep the run quick and exercise the line-to-line hand-over.
        ex = $urandom_range((sx + 7 > MAX_COORD) ? MAX_COORD : sx + 7,
                            (sx < 7) ? 0 : sx - 7);
        ey = $urandom_range((sy + 7 > MAX_COORD) ? MAX_COORD : sy + 7,
                            (sy < 7) ? 0 : sy - 7);
      end else if (kind < 75) begin
        ex = $urandom_range(MAX_COORD);
        ey = $urandom_range(MAX_COORD);
      end else if (kind < 88) begin
        // Exact diagonals, where the axis choice is a tie.
        d = $urandom_range(MAX_COORD);
        a = $urandom_range(MAX_COORD - d);
        b = $urandom_range(MAX_COORD - d);
        if ($urandom_range(1)) begin sx = a; ex = a + d; end else begin sx = a + d; ex = a; end
        if ($urandom_range(1)) begin sy = b; ey = b + d; end else begin sy = b + d; ey = b; end
      end else if (kind < 96) begin
        // Axis-aligned lines.
        if ($urandom_range(1)) begin
          ex = $urandom_range(MAX_COORD);
          ey = sy;
        end else begin
          ex = sx;
          ey = $urandom_range(MAX_COORD);
        end
      end else begin
        ex = sx;
        ey = sy;
      end
      add_line(sx, sy, ex, ey, (i == 150) || (i == 300));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (line_q.size() != 0 || in_tvalid || points_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && points_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/blp_pkg.sv
design/blp_dp.sv
design/blp_ctrl.sv
design/bresenham_line_points.sv
tb/tb.sv
